// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the battery charge lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bvp_pkg.sv
// Types, constants and the discharge curve of the battery charge lookup.
package bvp_pkg;

	localparam int CURVE_POINTS = 16;
	localparam int IDX_W = $clog2(CURVE_POINTS);
	localparam int MV_W = 16;
	localparam int NOM_W = 13;
	localparam int PCT_W = 7;
	localparam int QUOT_W = 11;
	localparam int DIVD_W = MV_W + QUOT_W;
	localparam int CNT_W = $clog2(QUOT_W);
	localparam int MUL2_W = NOM_W + PCT_W;

	localparam logic [MV_W-1:0] FULL_MV_RST = 16'd4200;
	localparam logic [MV_W-1:0] LOW_MV_RST = 16'd3000;
	localparam logic [NOM_W-1:0] NOM_BASE_MV = 13'd3000;
	localparam logic [QUOT_W-1:0] NOM_SPAN_MV = 11'd1200;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

	localparam logic [NOM_W-1:0] CURVE_MV [CURVE_POINTS] = '{
		13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950, 13'd3910,
		13'd3870, 13'd3830, 13'd3800, 13'd3750, 13'd3700, 13'd3600, 13'd3300, 13'd3000
	};
	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
		7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd1, 7'd0
	};

	typedef enum logic {
		REG_FULL_MV,
		REG_LOW_MV
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FULL,
		RES_FLAT,
		RES_INTERP
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_NOM,
		ST_SCAN,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     mul1;
		logic     div_start;
		logic     load_nom;
		logic     idx_inc;
		logic     seg_load;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic ge_full;
		logic le_empty;
		logic div_done;
		logic nom_ge_first;
		logic nom_le_last;
		logic seg_hit;
		logic seg_flat;
		logic idx_last;
		logic out_busy;
	} status_t;

endpackage

// File: hw/rtl/battery_voltage_to_percent_top.sv
// Flow: a voltage outside the configured span is answered straight from the end check; one
// rescaled to the empty end of the curve after the first 11-step pass of the shared restoring
// divider; otherwise the curve is scanned one segment at a time and a second pass interpolates.
// Throughput: one request in work at a time; the next is taken
// once the result sits in the output register, even while that result waits to be taken.
// Reset: asynchronous, active low; the thresholds return to 4200 mV (full) and 3000 mV (empty).
module battery_voltage_to_percent_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bvp_pkg::MV_W-1:0]   batt_mv,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bvp_pkg::PCT_W-1:0]  charge_percent,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [bvp_pkg::MV_W-1:0]   cfg_data
);

	bvp_pkg::cmd_t    cmd;
	bvp_pkg::status_t status;

	assign cfg_ready = 1'b1;

	bvp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bvp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.batt_mv        (batt_mv),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.charge_percent (charge_percent)
	);

endmodule

// File: hw/rtl/bvp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bvp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bvp_pkg::DIVD_W-1:0]  dividend,
	input  logic [bvp_pkg::MV_W-1:0]    divisor,
	output logic                        done,
	output logic [bvp_pkg::QUOT_W-1:0]  quotient
);

	logic [bvp_pkg::MV_W-1:0]   rem_q;
	logic [bvp_pkg::QUOT_W-1:0] dq_q;
	logic [bvp_pkg::MV_W-1:0]   dvs_q;
	logic [bvp_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bvp_pkg::MV_W:0]     trial;
	logic [bvp_pkg::MV_W:0]     diff;
	logic                       fits;

	// The quotient is known to fit in QUOT_W bits, so the upper dividend bits
	// already form a partial remainder below the divisor.
	assign trial = {rem_q, dq_q[bvp_pkg::QUOT_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bvp_pkg::CNT_W'(bvp_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[bvp_pkg::DIVD_W-1:bvp_pkg::QUOT_W];
			dq_q  <= dividend[bvp_pkg::QUOT_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[bvp_pkg::MV_W-1:0] : trial[bvp_pkg::MV_W-1:0];
			dq_q  <= {dq_q[bvp_pkg::QUOT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// File: hw/rtl/bvp_dp.sv
// Datapath: configuration registers, multipliers, curve lookup and result register.
`include "assert_macros.svh"

module bvp_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bvp_pkg::MV_W-1:0]   batt_mv,
	input  logic                       cfg_valid,
	input  logic                       cfg_index,
	input  logic [bvp_pkg::MV_W-1:0]   cfg_data,
	input  logic                       out_ready,
	input  bvp_pkg::cmd_t              cmd,
	output bvp_pkg::status_t           status,
	output logic                       out_valid,
	output logic [bvp_pkg::PCT_W-1:0]  charge_percent
);

	logic [bvp_pkg::MV_W-1:0]   full_q;
	logic [bvp_pkg::MV_W-1:0]   empty_q;
	logic [bvp_pkg::MV_W-1:0]   volt_q;
	logic [bvp_pkg::DIVD_W-1:0] prod_q;
	logic [bvp_pkg::MV_W-1:0]   divisor_q;
	logic [bvp_pkg::NOM_W-1:0]  nom_q;
	logic [bvp_pkg::IDX_W-1:0]  idx_q;
	logic [bvp_pkg::PCT_W-1:0]  base_q;
	logic [bvp_pkg::PCT_W-1:0]  res_q;
	logic                       out_valid_q;
	logic [bvp_pkg::PCT_W-1:0]  pct_out_q;

	logic [bvp_pkg::MV_W-1:0]   span;
	logic [bvp_pkg::MV_W-1:0]   vdiff;
	logic [bvp_pkg::DIVD_W-1:0] mul1;
	logic [bvp_pkg::IDX_W-1:0]  idx_dn;
	logic [bvp_pkg::NOM_W-1:0]  up_mv;
	logic [bvp_pkg::NOM_W-1:0]  dn_mv;
	logic [bvp_pkg::PCT_W-1:0]  up_pct;
	logic [bvp_pkg::PCT_W-1:0]  dn_pct;
	logic [bvp_pkg::NOM_W-1:0]  seg_dv;
	logic [bvp_pkg::PCT_W-1:0]  seg_dpct;
	logic [bvp_pkg::NOM_W-1:0]  nom_off;
	logic [bvp_pkg::MUL2_W-1:0] mul2;
	logic                       div_done;
	logic [bvp_pkg::QUOT_W-1:0] quot;
	logic [bvp_pkg::PCT_W-1:0]  res_next;

	assign span  = full_q - empty_q;
	assign vdiff = volt_q - empty_q;
	assign mul1  = {{(bvp_pkg::DIVD_W-bvp_pkg::MV_W){1'b0}}, vdiff}
		* {{(bvp_pkg::DIVD_W-bvp_pkg::QUOT_W){1'b0}}, bvp_pkg::NOM_SPAN_MV};

	// Segment between curve points idx_q (upper) and idx_q + 1 (lower).
	assign idx_dn   = idx_q + 1'b1;
	assign up_mv    = bvp_pkg::CURVE_MV[idx_q];
	assign dn_mv    = bvp_pkg::CURVE_MV[idx_dn];
	assign up_pct   = bvp_pkg::CURVE_PCT[idx_q];
	assign dn_pct   = bvp_pkg::CURVE_PCT[idx_dn];
	assign seg_dv   = up_mv - dn_mv;
	assign seg_dpct = up_pct - dn_pct;
	assign nom_off  = nom_q - dn_mv;
	assign mul2     = {{bvp_pkg::PCT_W{1'b0}}, nom_off} * {{bvp_pkg::NOM_W{1'b0}}, seg_dpct};

	bvp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		unique case (cmd.res_sel)
			bvp_pkg::RES_ZERO:   res_next = bvp_pkg::PCT_ZERO;
			bvp_pkg::RES_FULL:   res_next = bvp_pkg::PCT_FULL;
			bvp_pkg::RES_FLAT:   res_next = dn_pct;
			bvp_pkg::RES_INTERP: res_next = base_q + quot[bvp_pkg::PCT_W-1:0];
			default:             res_next = bvp_pkg::PCT_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= bvp_pkg::FULL_MV_RST;
			empty_q     <= bvp_pkg::LOW_MV_RST;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == bvp_pkg::REG_FULL_MV) begin
					full_q <= cfg_data;
				end else begin
					empty_q <= cfg_data;
				end
			end
			if (cmd.load_nom) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_dn;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			volt_q <= batt_mv;
		end
		if (cmd.mul1) begin
			prod_q    <= mul1;
			divisor_q <= span;
		end else if (cmd.seg_load) begin
			prod_q    <= {{(bvp_pkg::DIVD_W-bvp_pkg::MUL2_W){1'b0}}, mul2};
			divisor_q <= {{(bvp_pkg::MV_W-bvp_pkg::NOM_W){1'b0}}, seg_dv};
			base_q    <= dn_pct;
		end
		if (cmd.load_nom) begin
			nom_q <= bvp_pkg::NOM_BASE_MV
				+ {{(bvp_pkg::NOM_W-bvp_pkg::QUOT_W){1'b0}}, quot};
		end
		if (cmd.res_load) begin
			res_q <= res_next;
		end
		if (cmd.out_load) begin
			pct_out_q <= res_q;
		end
	end

	assign status.ge_full      = volt_q >= full_q;
	assign status.le_empty     = volt_q <= empty_q;
	assign status.div_done     = div_done;
	assign status.nom_ge_first = nom_q >= bvp_pkg::CURVE_MV[0];
	assign status.nom_le_last  = nom_q <= bvp_pkg::CURVE_MV[bvp_pkg::CURVE_POINTS-1];
	assign status.seg_hit      = nom_q >= dn_mv;
	assign status.seg_flat     = seg_dv == '0;
	assign status.idx_last     = idx_q == bvp_pkg::IDX_W'(bvp_pkg::CURVE_POINTS - 2);
	assign status.out_busy     = out_valid_q && !out_ready;

	assign out_valid      = out_valid_q;
	assign charge_percent = pct_out_q;

	`BVP_ASSERT_IMP(a_pct_range, clk, arst_n, out_valid_q, pct_out_q <= bvp_pkg::PCT_FULL, "charge above 100 percent")
	`BVP_ASSERT_NXT(a_nom_range, clk, arst_n, cmd.load_nom, (nom_q >= bvp_pkg::NOM_BASE_MV) && (nom_q < bvp_pkg::CURVE_MV[0]), "rescaled voltage outside nominal span")
	`BVP_ASSERT_NXT(a_seg_divisor, clk, arst_n, cmd.seg_load, divisor_q != '0, "segment division by zero")

endmodule

// File: hw/rtl/bvp_ctrl.sv
// Controller state machine sequencing the end checks, divisions and curve scan.
`include "assert_macros.svh"

module bvp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bvp_pkg::status_t   status,
	output bvp_pkg::cmd_t      cmd
);

	bvp_pkg::state_t state_q;
	bvp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = bvp_pkg::RES_ZERO;
		in_ready    = 1'b0;
		unique case (state_q)
			bvp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = bvp_pkg::ST_CHECK;
				end
			end
			bvp_pkg::ST_CHECK: begin
				// The full test wins when the configured span is empty or inverted.
				if (status.ge_full) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = bvp_pkg::RES_FULL;
					state_d      = bvp_pkg::ST_FINISH;
				end else if (status.le_empty) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = bvp_pkg::RES_ZERO;
					state_d      = bvp_pkg::ST_FINISH;
				end else begin
					cmd.mul1 = 1'b1;
					state_d  = bvp_pkg::ST_DIV1_GO;
				end
			end
			bvp_pkg::ST_DIV1_GO: begin
				cmd.div_start = 1'b1;
				state_d       = bvp_pkg::ST_DIV1_WAIT;
			end
			bvp_pkg::ST_DIV1_WAIT: begin
				if (status.div_done) begin
					cmd.load_nom = 1'b1;
					state_d      = bvp_pkg::ST_NOM;
				end
			end
			bvp_pkg::ST_NOM: begin
				if (status.nom_ge_first) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = bvp_pkg::RES_FULL;
					state_d      = bvp_pkg::ST_FINISH;
				end else if (status.nom_le_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = bvp_pkg::RES_ZERO;
					state_d      = bvp_pkg::ST_FINISH;
				end else begin
					state_d = bvp_pkg::ST_SCAN;
				end
			end
			bvp_pkg::ST_SCAN: begin
				if (status.seg_hit) begin
					if (status.seg_flat) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = bvp_pkg::RES_FLAT;
						state_d      = bvp_pkg::ST_FINISH;
					end else begin
						cmd.seg_load = 1'b1;
						state_d      = bvp_pkg::ST_DIV2_GO;
					end
				end else if (status.idx_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = bvp_pkg::RES_ZERO;
					state_d      = bvp_pkg::ST_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			bvp_pkg::ST_DIV2_GO: begin
				cmd.div_start = 1'b1;
				state_d       = bvp_pkg::ST_DIV2_WAIT;
			end
			bvp_pkg::ST_DIV2_WAIT: begin
				if (status.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = bvp_pkg::RES_INTERP;
					state_d      = bvp_pkg::ST_FINISH;
				end
			end
			bvp_pkg::ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = bvp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bvp_pkg::ST_IDLE;
			end
		endcase
	end

	`BVP_ASSERT_IMP(a_done_in_wait, clk, arst_n, status.div_done, (state_q == bvp_pkg::ST_DIV1_WAIT) || (state_q == bvp_pkg::ST_DIV2_WAIT), "divider finished outside a wait state")
	`BVP_ASSERT_IMP(a_out_free, clk, arst_n, cmd.out_load, !status.out_busy, "result overwrites one not yet taken")
	`BVP_ASSERT_IMP(a_scan_ends, clk, arst_n, (state_q == bvp_pkg::ST_SCAN) && status.idx_last, status.seg_hit, "curve scan ran past the last segment")

endmodule

// File: tb/tb_battery_voltage_to_percent_top.sv
// Self-checking testbench of the battery voltage to charge percent lookup.
module tb_battery_voltage_to_percent_top;

	localparam int KNEES = 16;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [bvp_pkg::MV_W-1:0] batt_mv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [bvp_pkg::PCT_W-1:0] charge_percent;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = bvp_pkg::REG_FULL_MV;
	logic [bvp_pkg::MV_W-1:0] cfg_data = '0;

	// Our own copy of the lithium discharge curve, highest voltage first.
	int unsigned knee_mv [KNEES] = '{
		4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910,
		3870, 3830, 3800, 3750, 3700, 3600, 3300, 3000
	};
	int unsigned knee_pct [KNEES] = '{
		100, 95, 90, 85, 80, 70, 60, 50,
		40, 30, 20, 15, 10, 5, 1, 0
	};

	logic [bvp_pkg::MV_W-1:0] full_mv_set = 16'd4200;
	logic [bvp_pkg::MV_W-1:0] low_mv_set = 16'd3000;
	logic [bvp_pkg::PCT_W-1:0] charge_due [$];
	logic [bvp_pkg::PCT_W-1:0] charge_want;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit idle_en = 1'b1;
	int rx_stall = 0;
	int rx_hold_cycles = 0;

	battery_voltage_to_percent_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.batt_mv        (batt_mv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.charge_percent (charge_percent),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, charge_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [bvp_pkg::PCT_W-1:0] calc_charge(
		input logic [bvp_pkg::MV_W-1:0] v);
		int unsigned span;
		int unsigned nom;
		int unsigned dv;
		int unsigned pct;
		if (v >= full_mv_set)
			return 7'd100;
		if (v <= low_mv_set)
			return 7'd0;
		span = int'(full_mv_set) - int'(low_mv_set);
		if (span == 0)
			nom = 3000;
		else
			nom = 3000 + ((int'(v) - int'(low_mv_set)) * 1200) / span;
		if (nom >= knee_mv[0])
			return 7'd100;
		if (nom <= knee_mv[KNEES-1])
			return 7'd0;
		for (int k = 0; k < KNEES - 1; k++) begin
			if (nom >= knee_mv[k+1]) begin
				dv = knee_mv[k] - knee_mv[k+1];
				if (dv == 0)
					return 7'(knee_pct[k+1]);
				pct = knee_pct[k+1] + ((nom - knee_mv[k+1]) * (knee_pct[k] - knee_pct[k+1])) / dv;
				return 7'(pct);
			end
		end
		return 7'd0;
	endfunction

	// Result side: checks every accepted result and draws its own stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (charge_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, charge_percent);
					mismatch_count++;
				end else begin
					charge_want = charge_due.pop_front();
					if (charge_percent !== charge_want) begin
						$display("%0t: charge_percent mismatch, expected %0d, actual %0d",
							$time, charge_want, charge_percent);
						mismatch_count++;
					end
				end
				rx_stall = idle_en ? $urandom_range(0, 5) : 0;
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_voltage(input logic [bvp_pkg::MV_W-1:0] v);
		int gap;
		gap = idle_en ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		batt_mv <= v;
		do @(posedge clk); while (!in_ready);
		charge_due.push_back(calc_charge(v));
	endtask

	task automatic wait_drained(input int tail);
		in_valid <= 1'b0;
		while (charge_due.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Writes both thresholds back to back; only called while the block is idle.
	task automatic set_span(input logic [bvp_pkg::MV_W-1:0] full,
		input logic [bvp_pkg::MV_W-1:0] empty);
		cfg_valid <= 1'b1;
		cfg_index <= bvp_pkg::REG_FULL_MV;
		cfg_data <= full;
		do @(posedge clk); while (!cfg_ready);
		full_mv_set = full;
		cfg_index <= bvp_pkg::REG_LOW_MV;
		cfg_data <= empty;
		do @(posedge clk); while (!cfg_ready);
		low_mv_set = empty;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [bvp_pkg::MV_W-1:0] pick_voltage();
		int unsigned lo;
		int unsigned hi;
		if (full_mv_set <= low_mv_set || $urandom_range(0, 4) == 0)
			return 16'($urandom);
		lo = (low_mv_set > 50) ? low_mv_set - 50 : 0;
		hi = (int'(full_mv_set) + 50 > 65535) ? 65535 : full_mv_set + 50;
		return 16'($urandom_range(lo, hi));
	endfunction

	task automatic test_reset_thresholds();
		logic [bvp_pkg::MV_W-1:0] picks [$];
		picks = '{16'd0, 16'd65535, 16'd4200, 16'd4199, 16'd3000, 16'd3001,
			16'd4150, 16'd3910, 16'd3300, 16'd3301, 16'd3600, 16'd4100};
		foreach (picks[i])
			send_voltage(picks[i]);
		wait_drained(8);
	endtask

	task automatic test_threshold_extremes();
		set_span(16'hFFFF, 16'h0000);
		send_voltage(16'd0);
		send_voltage(16'd1);
		send_voltage(16'd32768);
		send_voltage(16'd65534);
		send_voltage(16'd65535);
		wait_drained(8);
		// Equal thresholds: the full test wins for every voltage at or above them.
		set_span(16'd0, 16'd0);
		send_voltage(16'd0);
		send_voltage(16'd1);
		wait_drained(8);
		// Full below empty: no division takes place.
		set_span(16'd1000, 16'd5000);
		send_voltage(16'd999);
		send_voltage(16'd1000);
		send_voltage(16'd3000);
		send_voltage(16'd5000);
		wait_drained(8);
		set_span(16'd3001, 16'd3000);
		send_voltage(16'd3000);
		send_voltage(16'd3001);
		wait_drained(8);
		set_span(16'd3002, 16'd3000);
		send_voltage(16'd3001);
		wait_drained(8);
	endtask

	task automatic test_random_spans();
		logic [bvp_pkg::MV_W-1:0] full;
		logic [bvp_pkg::MV_W-1:0] empty;
		for (int phase = 0; phase < 6; phase++) begin
			unique case (phase % 6)
				2: begin
					full = 16'($urandom);
					empty = 16'($urandom);
				end
				3: begin
					empty = 16'($urandom_range(0, 65000));
					full = empty + 16'($urandom_range(1, 40));
				end
				5: begin
					full = 16'($urandom_range(0, 3000));
					empty = 16'($urandom_range(3000, 65535));
				end
				default: begin
					empty = 16'($urandom_range(2500, 3400));
					full = 16'($urandom_range(3900, 4400));
				end
			endcase
			set_span(full, empty);
			idle_en = (phase != 1) && (phase != 4);
			repeat (310)
				send_voltage(pick_voltage());
			wait_drained(8);
		end
		idle_en = 1'b1;
	endtask

	task automatic test_output_backpressure();
		set_span(16'd4200, 16'd3000);
		idle_en = 1'b0;
		rx_hold_cycles = 400;
		repeat (40)
			send_voltage(pick_voltage());
		idle_en = 1'b1;
		wait_drained(8);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_thresholds();
		test_threshold_extremes();
		test_random_spans();
		test_output_backpressure();
		wait_drained(60);
		if (mismatch_count == 0 && charge_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
